// ----- hw/rtl/phaser_pkg.sv -----
// Shared types, constants and the sine table function for the phaser.
// Used by the controller, the datapath and the top level.
package phaser_pkg;

   localparam int SampleWidth = 16;
   localparam int WordWidth   = 24;
   localparam int CsrWidth    = 32;
   localparam int CsrIdxWidth = 3;

   localparam logic [CsrIdxWidth-1:0] CSR_SWEEP_LOW  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SWEEP_HIGH = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_LFO_STEP   = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_FEEDBACK   = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_WET_MIX    = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SINE,
      ST_SWEEP,
      ST_DIV,
      ST_FEED,
      ST_STAGE_Y,
      ST_STAGE_M,
      ST_MIX,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic sine;
      logic sweep;
      logic div_start;
      logic feed;
      logic stage_y;
      logic stage_m;
      logic mix;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_stage;
   } status_type;

   // The series divides by 110, 72, 42, 20 and 6. Each quotient has a numerator
   // below 2^32, so multiplying by floor(2^(32+l)/d)+1 and shifting right by
   // 32+l, with 2^(l-1) < d <= 2^l, gives the exact floor.
   localparam int SineShift [5] = '{39, 39, 38, 37, 35};
   localparam longint unsigned SineRecip [5] = '{
      (64'd1 << 39) / 64'd110 + 64'd1,
      (64'd1 << 39) / 64'd72 + 64'd1,
      (64'd1 << 38) / 64'd42 + 64'd1,
      (64'd1 << 37) / 64'd20 + 64'd1,
      (64'd1 << 35) / 64'd6 + 64'd1
   };

   // Quarter-wave Taylor series, used only on constants at elaboration.
   // quad is the quadrant, frac the Q30 position inside it.
   function automatic logic signed [16:0] sine_entry(input longint unsigned quad,
                                                     input longint unsigned frac);
      longint unsigned t, x, x2, h, s, v, n;
      logic [95:0] prod;
      t = quad[0] ? 64'd1073741824 - frac : frac;
      x = (t * 64'd1686629713) >> 30;
      x2 = (x * x) >> 30;
      h = 64'd1073741824;
      for (int i = 0; i < 5; i++) begin
         n = (x2 * h) >> 30;
         prod = 96'(n) * 96'(SineRecip[i]);
         h = 64'd1073741824 - 64'(prod >> SineShift[i]);
      end
      s = (x * h) >> 30;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      return (quad >= 2) ? -17'(signed'(v[16:0])) : 17'(signed'(v[16:0]));
   endfunction

endpackage

// ----- hw/rtl/phaser_if.sv -----
// Valid/ready channel carrying one signed sample.
// Depends on phaser_pkg for the sample width.
interface phaser_if import phaser_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [SampleWidth-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// ----- hw/rtl/phaser_ctrl.sv -----
// Sequencer for the phaser: steps the datapath through one sample.
// Depends on phaser_pkg.
module phaser_ctrl import phaser_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SINE;
            end
         end
         ST_SINE: begin
            cmd.sine = 1'b1;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = ST_FEED;
         end
         ST_FEED: begin
            if (status.div_done) begin
               cmd.feed = 1'b1;
               state_in = ST_STAGE_Y;
            end
         end
         ST_STAGE_Y: begin
            cmd.stage_y = 1'b1;
            state_in = ST_STAGE_M;
         end
         ST_STAGE_M: begin
            cmd.stage_m = 1'b1;
            state_in = status.last_stage ? ST_MIX : ST_STAGE_Y;
         end
         ST_MIX: begin
            cmd.mix = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ----- hw/rtl/phaser_dp.sv -----
// Datapath for the phaser: LFO, sweep, restoring divider, allpass chain, mix.
// Depends on phaser_pkg; driven by phaser_ctrl commands.
module phaser_dp import phaser_pkg::*; #(
   parameter int STAGE_COUNT  = 6,
   parameter int SINE_ENTRIES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic signed [SampleWidth-1:0] sample_in,
   input  logic [15:0]                   sweep_low,
   input  logic [15:0]                   sweep_high,
   input  logic [31:0]                   lfo_step,
   input  logic [14:0]                   feedback_gain,
   input  logic [15:0]                   wet_mix,
   output logic signed [SampleWidth-1:0] sample_out
);
   localparam int IdxW = $clog2(SINE_ENTRIES);
   localparam int StW  = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

   logic signed [16:0] sine_rom [SINE_ENTRIES];
   for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
      localparam longint unsigned Quad = longint'(4 * k / SINE_ENTRIES);
      localparam longint unsigned Frac =
         ((longint'(4 * k) % SINE_ENTRIES) << 30) / SINE_ENTRIES;
      assign sine_rom[k] = sine_entry(Quad, Frac);
   end

   logic [31:0] phase_ff;
   logic signed [SampleWidth-1:0] x_ff;
   logic [16:0] u_ff;
   logic [16:0] d_ff;
   logic [17:0] a_ff;
   logic signed [WordWidth-1:0] last_ff, y_ff, xi_ff;
   logic signed [WordWidth-1:0] mem_ff [STAGE_COUNT];
   logic [StW-1:0] st_ff;
   logic signed [SampleWidth-1:0] out_ff;

   // Restoring divider, one quotient bit per cycle.
   logic [32:0] rem_ff;
   logic [32:0] num_ff;
   logic [17:0] den_ff;
   logic [17:0] quo_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;

   function automatic logic signed [WordWidth-1:0] sat24(input logic signed [47:0] v);
      if (v > 48'sd8388607) return 24'sh7FFFFF;
      if (v < -48'sd8388608) return 24'sh800000;
      return v[WordWidth-1:0];
   endfunction

   // Table index rounds phase*N/2^32; an index equal to N wraps to entry zero.
   logic [44:0] idx_prod;
   logic [IdxW:0] idx_full;
   logic [IdxW-1:0] idx;
   assign idx_prod = 45'(phase_ff) * 45'(SINE_ENTRIES) + 45'h8000_0000;
   assign idx_full = idx_prod[32 +: IdxW+1];
   assign idx = (idx_full >= (IdxW+1)'(SINE_ENTRIES)) ? '0 : idx_full[IdxW-1:0];

   logic [33:0] sweep_sum;
   assign sweep_sum = 34'(sweep_low) * 34'(17'd65536 - u_ff) + 34'(sweep_high) * 34'(u_ff);

   logic signed [47:0] fb_prod, ya_prod, ma_prod, mix_prod;
   logic signed [WordWidth-1:0] y_new;
   assign fb_prod = 48'(last_ff) * 48'(signed'({1'b0, feedback_gain}));
   assign ya_prod = 48'(xi_ff) * 48'(signed'({1'b0, a_ff}));
   assign y_new = sat24(48'(mem_ff[st_ff]) - ((ya_prod + 48'sd32768) >>> 16));
   assign ma_prod = 48'(y_ff) * 48'(signed'({1'b0, a_ff}));

   logic [16:0] w;
   assign w = (wet_mix > 16'd32768) ? 17'd32768 : {1'b0, wet_mix};
   assign mix_prod = 48'(signed'({1'b0, 17'd32768 - w})) * 48'(x_ff)
                   + 48'(signed'({1'b0, w})) * 48'(y_ff);
   logic signed [47:0] mix_r;
   assign mix_r = (mix_prod + 48'sd16384) >>> 15;

   logic [33:0] trial;
   assign trial = {rem_ff, num_ff[32]} - {16'd0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         last_ff  <= '0;
         busy_ff  <= 1'b0;
         for (int i = 0; i < STAGE_COUNT; i++) mem_ff[i] <= '0;
      end else begin
         if (cmd.load) begin
            x_ff  <= sample_in;
            st_ff <= '0;
         end
         if (cmd.sine) begin
            u_ff <= 17'(sine_rom[idx] + 17'sd32768);
            phase_ff <= phase_ff + lfo_step;
         end
         if (cmd.sweep) d_ff <= sweep_sum[32:16];
         if (cmd.div_start) begin
            num_ff  <= {(17'd65536 - d_ff), 16'd0} + 33'((17'd65536 + d_ff) >> 1);
            den_ff  <= 18'(17'd65536 + d_ff);
            rem_ff  <= '0;
            cnt_ff  <= 6'd33;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!trial[33]) begin
               rem_ff <= trial[32:0];
               quo_ff <= {quo_ff[16:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[31:0], num_ff[32]};
               quo_ff <= {quo_ff[16:0], 1'b0};
            end
            num_ff <= {num_ff[31:0], 1'b0};
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) busy_ff <= 1'b0;
         end
         if (cmd.feed) begin
            a_ff  <= quo_ff;
            xi_ff <= sat24(48'(x_ff) + ((fb_prod + 48'sd16384) >>> 15));
         end
         if (cmd.stage_y) y_ff <= y_new;
         if (cmd.stage_m) begin
            mem_ff[st_ff] <= sat24(((ma_prod + 48'sd32768) >>> 16) + 48'(xi_ff));
            xi_ff <= y_ff;
            st_ff <= st_ff + StW'(1);
            if (status.last_stage) last_ff <= y_ff;
         end
         if (cmd.mix) begin
            out_ff <= (mix_r > 48'sd32767) ? 16'sh7FFF :
                      (mix_r < -48'sd32768) ? 16'sh8000 : mix_r[15:0];
         end
      end
   end

   assign status.div_done   = !busy_ff;
   assign status.last_stage = (32'(st_ff) == STAGE_COUNT - 1);
   assign sample_out = out_ff;
endmodule

// ----- hw/rtl/phaser_allpass_lfo_top.sv -----
// Phaser top level: one request in, one result out, one sample at a time.
// After a request is accepted the controller steps through the sine lookup,
// the sweep, the 33-step serial divider, the feedback, a Y and an M state per
// allpass stage and the mix, then holds the result; the next request is taken
// only after the result has been taken.
// Synchronous active-high reset clears the LFO phase, feedback word,
// stage memories and restores the register defaults.
module phaser_allpass_lfo_top import phaser_pkg::*; #(
   parameter int STAGE_COUNT  = 6,
   parameter int SINE_ENTRIES = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   phaser_if.sink                 req,
   phaser_if.source               rsp,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrWidth-1:0]    csr_wdata
);
   logic [15:0] sweep_low_ff, sweep_high_ff, wet_ff;
   logic [31:0] step_ff;
   logic [14:0] fb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_low_ff  <= 16'd546;
         sweep_high_ff <= 16'd4642;
         step_ff       <= 32'd8948;
         fb_ff         <= 15'd22938;
         wet_ff        <= 16'd9830;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SWEEP_LOW:  sweep_low_ff  <= csr_wdata[15:0];
            CSR_SWEEP_HIGH: sweep_high_ff <= csr_wdata[15:0];
            CSR_LFO_STEP:   step_ff       <= csr_wdata;
            CSR_FEEDBACK:   fb_ff         <= csr_wdata[14:0];
            CSR_WET_MIX:    wet_ff        <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   cmd_type    cmd;
   status_type status;

   phaser_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .status, .cmd
   );

   phaser_dp #(.STAGE_COUNT(STAGE_COUNT), .SINE_ENTRIES(SINE_ENTRIES)) u_dp (
      .clock, .reset, .cmd, .status,
      .sample_in(req.sample),
      .sweep_low(sweep_low_ff), .sweep_high(sweep_high_ff),
      .lfo_step(step_ff), .feedback_gain(fb_ff), .wet_mix(wet_ff),
      .sample_out(rsp.sample)
   );

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !rsp.valid)
      else $error("result shown right after request");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.sample)))
      else $error("result dropped while stalled");
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("accepting while result pending");
`endif
endmodule
